FILE: hdl/cbf_pkg.sv
// shared types and constants for the xor-field counting bloom filter
package cbf_pkg;

	localparam int OP_W          = 2;
	localparam int ADDR_W        = 64;
	localparam int COUNT_W       = 8;
	localparam int ENTRY_INDEX_W = 12;
	localparam int S_TDATA_W     = 72;
	localparam int M_TDATA_W     = 24;
	localparam int CFG_IDX_W     = 8;
	localparam int CFG_DATA_W    = 8;

	localparam int NUM_FIELDS = 3;
	localparam int OFFSET_W   = 6;
	localparam int FCOUNT_W   = 2;
	localparam int LOW_W      = 6;
	localparam int WIDTH_W    = 4;
	localparam int POS_W      = 7;
	localparam int WEFF_W     = 5;

	localparam logic [OP_W-1:0] OP_INC   = 2'd0;
	localparam logic [OP_W-1:0] OP_DEC   = 2'd1;
	localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_OFFSET = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FIELD_COUNT  = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_F0_LOW       = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_F0_WIDTH     = 8'd3;
	localparam logic [CFG_IDX_W-1:0] REG_F1_LOW       = 8'd4;
	localparam logic [CFG_IDX_W-1:0] REG_F1_WIDTH     = 8'd5;
	localparam logic [CFG_IDX_W-1:0] REG_F2_LOW       = 8'd6;
	localparam logic [CFG_IDX_W-1:0] REG_F2_WIDTH     = 8'd7;

	localparam logic [OFFSET_W-1:0] RST_BLOCK_OFFSET = 6'd6;
	localparam logic [FCOUNT_W-1:0] RST_FIELD_COUNT  = 2'd1;
	localparam logic [LOW_W-1:0]    RST_F0_LOW       = 6'd0;
	localparam logic [LOW_W-1:0]    RST_F1_LOW       = 6'd12;
	localparam logic [LOW_W-1:0]    RST_F2_LOW       = 6'd24;
	localparam logic [WIDTH_W-1:0]  RST_FIELD_WIDTH  = 4'd12;

	typedef struct packed {
		logic [OFFSET_W-1:0]                  block_offset_bits;
		logic [FCOUNT_W-1:0]                  field_count;
		logic [NUM_FIELDS-1:0][LOW_W-1:0]     field_low_bit;
		logic [NUM_FIELDS-1:0][WIDTH_W-1:0]   field_width;
	} cfg_t;

	// stage control from the front end into the table stage
	typedef struct packed {
		logic            advance;
		logic            valid;
		logic [OP_W-1:0] op;
	} ctl_t;

	// table stage status back to the front end
	typedef struct packed {
		logic clear_busy;
		logic valid;
	} sts_t;

endpackage

FILE: hdl/xor_field_counting_bloom_filter_top.sv
// top level of the xor-field counting bloom filter
//
// channel  direction  handshake              payload
// s_*      in         s_tvalid / s_tready    op, address
// m_*      out        m_tvalid / m_tready    count, entry_index
// cfg_*    in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one item per cycle while the output is not stalled and no clearing pass runs; an accepted item
// goes through the input register, the table read stage, then the output register
// after reset a clearing pass zeroes all 2^floor(log2(TABLE_ENTRIES)) table entries,
// 4096 by default, and s_tready stays low meanwhile
// a stalled output freezes the whole pipe; the table memory does at most one
// read and one write per cycle, with forwarding between neighbor items
module xor_field_counting_bloom_filter_top #(
	parameter int TABLE_ENTRIES = 4096,
	parameter int COUNTER_BITS  = 8,
	parameter int MAX_FIELDS    = 3
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [cbf_pkg::S_TDATA_W-1:0]     s_tdata,   // op, address, zero pad
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [cbf_pkg::M_TDATA_W-1:0]     m_tdata,   // count, entry_index, zero pad
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [cbf_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [cbf_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int IDX_W = $clog2(TABLE_ENTRIES + 1) - 1;

	cbf_pkg::cfg_t cfg_q;
	cbf_pkg::ctl_t ctl;
	cbf_pkg::sts_t sts;

	logic                          advance;
	logic                          valid_s1;
	logic [cbf_pkg::OP_W-1:0]      op_s1;
	logic [cbf_pkg::ADDR_W-1:0]    addr_s1;
	logic [IDX_W-1:0]              idx_s1;

	logic [cbf_pkg::COUNT_W-1:0]       count_s2;
	logic [cbf_pkg::ENTRY_INDEX_W-1:0] entry_index_s2;
	logic                              m_valid_q;
	logic [cbf_pkg::COUNT_W-1:0]       count_q;
	logic [cbf_pkg::ENTRY_INDEX_W-1:0] entry_index_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.block_offset_bits <= cbf_pkg::RST_BLOCK_OFFSET;
			cfg_q.field_count <= cbf_pkg::RST_FIELD_COUNT;
			cfg_q.field_low_bit[0] <= cbf_pkg::RST_F0_LOW;
			cfg_q.field_low_bit[1] <= cbf_pkg::RST_F1_LOW;
			cfg_q.field_low_bit[2] <= cbf_pkg::RST_F2_LOW;
			cfg_q.field_width[0] <= cbf_pkg::RST_FIELD_WIDTH;
			cfg_q.field_width[1] <= cbf_pkg::RST_FIELD_WIDTH;
			cfg_q.field_width[2] <= cbf_pkg::RST_FIELD_WIDTH;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				cbf_pkg::REG_BLOCK_OFFSET:
					cfg_q.block_offset_bits <= cfg_data[cbf_pkg::OFFSET_W-1:0];
				cbf_pkg::REG_FIELD_COUNT:
					cfg_q.field_count <= cfg_data[cbf_pkg::FCOUNT_W-1:0];
				cbf_pkg::REG_F0_LOW:
					cfg_q.field_low_bit[0] <= cfg_data[cbf_pkg::LOW_W-1:0];
				cbf_pkg::REG_F0_WIDTH:
					cfg_q.field_width[0] <= cfg_data[cbf_pkg::WIDTH_W-1:0];
				cbf_pkg::REG_F1_LOW:
					cfg_q.field_low_bit[1] <= cfg_data[cbf_pkg::LOW_W-1:0];
				cbf_pkg::REG_F1_WIDTH:
					cfg_q.field_width[1] <= cfg_data[cbf_pkg::WIDTH_W-1:0];
				cbf_pkg::REG_F2_LOW:
					cfg_q.field_low_bit[2] <= cfg_data[cbf_pkg::LOW_W-1:0];
				cbf_pkg::REG_F2_WIDTH:
					cfg_q.field_width[2] <= cfg_data[cbf_pkg::WIDTH_W-1:0];
				default: ;
			endcase
		end
	end

	// the whole pipe moves when the output register can take a result
	assign advance = !m_valid_q || m_tready;
	assign s_tready = advance && !sts.clear_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= s_tvalid && s_tready;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1 <= s_tdata[cbf_pkg::OP_W-1:0];
			addr_s1 <= s_tdata[cbf_pkg::OP_W +: cbf_pkg::ADDR_W];
		end
	end

	cbf_hash #(
		.IDX_W      (IDX_W),
		.MAX_FIELDS (MAX_FIELDS)
	) u_hash (
		.cfg     (cfg_q),
		.address (addr_s1),
		.idx     (idx_s1)
	);

	assign ctl.advance = advance;
	assign ctl.valid = valid_s1;
	assign ctl.op = op_s1;

	cbf_table #(
		.IDX_W (IDX_W),
		.CNT_W (COUNTER_BITS)
	) u_table (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.idx         (idx_s1),
		.sts         (sts),
		.count       (count_s2),
		.entry_index (entry_index_s2)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance) begin
			m_valid_q <= sts.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			count_q <= count_s2;
			entry_index_q <= entry_index_s2;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata = {
		{(cbf_pkg::M_TDATA_W - cbf_pkg::COUNT_W - cbf_pkg::ENTRY_INDEX_W){1'b0}},
		entry_index_q, count_q};

	// no item may be in flight while the table is being cleared
	a_clear_empty: assert property (@(posedge clk) disable iff (!arst_n)
		sts.clear_busy |-> (!valid_s1 && !sts.valid && !m_valid_q))
		else $error("item in flight during table clearing");

	// an item in the input register reaches the table stage on the next move
	a_s1_to_s2: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && valid_s1) |=> sts.valid)
		else $error("item lost between input register and table stage");

	// a new result only comes from the table stage
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(sts.valid))
		else $error("result appeared without a table stage item");

endmodule

FILE: hdl/cbf_hash.sv
// xor of up to three address bitfields into a table index
module cbf_hash #(
	parameter int IDX_W      = 12,
	parameter int MAX_FIELDS = 3
) (
	input  cbf_pkg::cfg_t                  cfg,
	input  logic [cbf_pkg::ADDR_W-1:0]     address,
	output logic [IDX_W-1:0]               idx
);

	logic [cbf_pkg::FCOUNT_W-1:0] n_fields;

	always_comb begin
		n_fields = (cfg.field_count == '0) ? cbf_pkg::FCOUNT_W'(1) : cfg.field_count;
		if (n_fields > cbf_pkg::FCOUNT_W'(MAX_FIELDS)) begin
			n_fields = cbf_pkg::FCOUNT_W'(MAX_FIELDS);
		end
	end

	always_comb begin
		logic [cbf_pkg::POS_W-1:0]  pos;
		logic [cbf_pkg::WEFF_W-1:0] weff;
		logic [IDX_W-1:0]           mask;
		logic [cbf_pkg::ADDR_W-1:0] shifted;
		idx = '0;
		for (int i = 0; i < cbf_pkg::NUM_FIELDS; i++) begin
			pos = {1'b0, cfg.block_offset_bits} + {1'b0, cfg.field_low_bit[i]};
			weff = (cfg.field_width[i] == '0) ? cbf_pkg::WEFF_W'(1)
				: {1'b0, cfg.field_width[i]};
			if (weff > cbf_pkg::WEFF_W'(IDX_W)) begin
				weff = cbf_pkg::WEFF_W'(IDX_W);
			end
			// shifting all ones past the top leaves a full mask
			mask = ~({IDX_W{1'b1}} << weff);
			// bits at and above 64 read as zero
			shifted = pos[cbf_pkg::POS_W-1] ? '0 : (address >> pos[cbf_pkg::POS_W-2:0]);
			if (cbf_pkg::FCOUNT_W'(i) < n_fields) begin
				idx = idx ^ (shifted[IDX_W-1:0] & mask);
			end
		end
	end

endmodule

FILE: hdl/cbf_table.sv
// counter memory with clearing pass, read-modify-write stage and forwarding
module cbf_table #(
	parameter int IDX_W  = 12,
	parameter int CNT_W  = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  cbf_pkg::ctl_t                       ctl,
	input  logic [IDX_W-1:0]                    idx,
	output cbf_pkg::sts_t                       sts,
	output logic [cbf_pkg::COUNT_W-1:0]         count,
	output logic [cbf_pkg::ENTRY_INDEX_W-1:0]   entry_index
);

	localparam int DEPTH = 1 << IDX_W;

	logic [CNT_W-1:0] mem [DEPTH];

	logic             clr_busy_q;
	logic [IDX_W-1:0] clr_addr_q;

	logic             valid_s2;
	logic [cbf_pkg::OP_W-1:0] op_s2;
	logic [IDX_W-1:0] idx_s2;
	logic [CNT_W-1:0] rd_data_s2;
	logic             fwd_hit_s2;
	logic [CNT_W-1:0] fwd_val_s2;

	logic [CNT_W-1:0] base_cnt;
	logic [CNT_W-1:0] new_cnt;
	logic             wr_item;

	logic [CNT_W+cbf_pkg::COUNT_W-1:0]       cnt_ext;
	logic [IDX_W+cbf_pkg::ENTRY_INDEX_W-1:0] idx_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + IDX_W'(1);
			if (clr_addr_q == {IDX_W{1'b1}}) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ctl.advance) begin
			valid_s2 <= ctl.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.advance) begin
			op_s2 <= ctl.op;
			idx_s2 <= idx;
			// the item ahead writes on this same edge, so the read misses it
			fwd_hit_s2 <= valid_s2 && (idx_s2 == idx);
			fwd_val_s2 <= new_cnt;
		end
	end

	assign wr_item = ctl.advance && valid_s2;

	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			mem[clr_addr_q] <= '0;
		end else if (wr_item) begin
			mem[idx_s2] <= new_cnt;
		end
		if (ctl.advance) begin
			rd_data_s2 <= mem[idx];
		end
	end

	assign base_cnt = fwd_hit_s2 ? fwd_val_s2 : rd_data_s2;

	always_comb begin
		new_cnt = base_cnt;
		unique case (op_s2)
			cbf_pkg::OP_INC: begin
				if (base_cnt != {CNT_W{1'b1}}) begin
					new_cnt = base_cnt + CNT_W'(1);
				end
			end
			cbf_pkg::OP_DEC: begin
				if (base_cnt != '0) begin
					new_cnt = base_cnt - CNT_W'(1);
				end
			end
			default: new_cnt = base_cnt;
		endcase
	end

	assign cnt_ext = {{cbf_pkg::COUNT_W{1'b0}}, new_cnt};
	assign idx_ext = {{cbf_pkg::ENTRY_INDEX_W{1'b0}}, idx_s2};
	assign count = cnt_ext[cbf_pkg::COUNT_W-1:0];
	assign entry_index = idx_ext[cbf_pkg::ENTRY_INDEX_W-1:0];

	assign sts.clear_busy = clr_busy_q;
	assign sts.valid = valid_s2;

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 100ps
// self-checking testbench for the xor-field counting bloom filter top level
module tb_top;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int TABLE_DEPTH    = 1 << cbf_pkg::ENTRY_INDEX_W;
	localparam int PACE_NONE      = 0;
	localparam int PACE_FULL      = 1;
	localparam int PACE_LIGHT     = 2;

	localparam logic [cbf_pkg::OP_W-1:0]      OP_SPARE  = 2'd3;
	localparam logic [cbf_pkg::CFG_IDX_W-1:0] REG_NONE  = 8'hff;
	localparam logic [cbf_pkg::COUNT_W-1:0]   COUNT_MAX = '1;

	typedef struct packed {
		logic [cbf_pkg::OP_W-1:0]   op;
		logic [cbf_pkg::ADDR_W-1:0] address;
	} lookup_t;

	typedef struct packed {
		logic [cbf_pkg::COUNT_W-1:0]       count;
		logic [cbf_pkg::ENTRY_INDEX_W-1:0] entry_index;
	} tally_t;

	logic                               clk       = 1'b0;
	logic                               arst_n    = 1'b0;
	logic                               s_tvalid  = 1'b0;
	logic                               s_tready;
	logic [cbf_pkg::S_TDATA_W-1:0]      s_tdata   = '0;
	logic                               m_tvalid;
	logic                               m_tready  = 1'b0;
	logic [cbf_pkg::M_TDATA_W-1:0]      m_tdata;
	logic                               cfg_valid = 1'b0;
	logic                               cfg_ready;
	logic [cbf_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
	logic [cbf_pkg::CFG_DATA_W-1:0]     cfg_data  = '0;

	// predictor state: counters and register copy
	logic [cbf_pkg::COUNT_W-1:0]  filter_counts [TABLE_DEPTH];
	logic [cbf_pkg::OFFSET_W-1:0] cfg_offset;
	logic [cbf_pkg::FCOUNT_W-1:0] cfg_fcount;
	logic [cbf_pkg::LOW_W-1:0]    cfg_low   [cbf_pkg::NUM_FIELDS];
	logic [cbf_pkg::WIDTH_W-1:0]  cfg_width [cbf_pkg::NUM_FIELDS];

	lookup_t pending_lookups [$];
	tally_t  awaited_tallies [$];
	lookup_t cur_lookup;

	int  send_pace    = PACE_NONE;
	int  recv_pace    = PACE_NONE;
	int  hold_request = 0;
	int  send_wait    = 0;
	int  stall_left   = 0;
	int  hold_left    = 0;
	int  quiet_cycles = 0;
	int  fail_count   = 0;
	bit  item_done    = 1'b0;
	bit  result_seen  = 1'b0;

	xor_field_counting_bloom_filter_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic int draw_wait(input int pace);
		case (pace)
			PACE_NONE: return 0;
			PACE_FULL: return $urandom_range(0, 16);
			default:   return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : 0;
		endcase
	endfunction

	function automatic logic [cbf_pkg::ENTRY_INDEX_W-1:0] hash_entry(
			input logic [cbf_pkg::ADDR_W-1:0] addr);
		logic [cbf_pkg::ENTRY_INDEX_W-1:0] h;
		logic [cbf_pkg::ADDR_W-1:0]        bits;
		int                                nf, w, pos, i;
		h  = '0;
		nf = (cfg_fcount == 0) ? 1 : int'(cfg_fcount);
		for (i = 0; i < nf; i++) begin
			w = (cfg_width[i] == 0) ? 1 : int'(cfg_width[i]);
			if (w > cbf_pkg::ENTRY_INDEX_W)
				w = cbf_pkg::ENTRY_INDEX_W;
			pos = int'(cfg_offset) + int'(cfg_low[i]);
			// address bits above the top read as zero
			if (pos < cbf_pkg::ADDR_W) begin
				bits = (addr >> pos) & ((64'd1 << w) - 64'd1);
				h    = h ^ bits[cbf_pkg::ENTRY_INDEX_W-1:0];
			end
		end
		return h;
	endfunction

	task automatic apply_filter_op(input lookup_t req);
		tally_t                      t;
		logic [cbf_pkg::COUNT_W-1:0] c;
		t.entry_index = hash_entry(req.address);
		c = filter_counts[t.entry_index];
		case (req.op)
			cbf_pkg::OP_INC:  if (c != COUNT_MAX) c = c + 1'b1;
			cbf_pkg::OP_DEC:  if (c != '0) c = c - 1'b1;
			default: ;
		endcase
		filter_counts[t.entry_index] = c;
		t.count = c;
		awaited_tallies.push_back(t);
	endtask

	task automatic write_reg(input logic [cbf_pkg::CFG_IDX_W-1:0] idx,
			input logic [cbf_pkg::CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		case (idx)
			cbf_pkg::REG_BLOCK_OFFSET: cfg_offset   = data[cbf_pkg::OFFSET_W-1:0];
			cbf_pkg::REG_FIELD_COUNT:  cfg_fcount   = data[cbf_pkg::FCOUNT_W-1:0];
			cbf_pkg::REG_F0_LOW:       cfg_low[0]   = data[cbf_pkg::LOW_W-1:0];
			cbf_pkg::REG_F0_WIDTH:     cfg_width[0] = data[cbf_pkg::WIDTH_W-1:0];
			cbf_pkg::REG_F1_LOW:       cfg_low[1]   = data[cbf_pkg::LOW_W-1:0];
			cbf_pkg::REG_F1_WIDTH:     cfg_width[1] = data[cbf_pkg::WIDTH_W-1:0];
			cbf_pkg::REG_F2_LOW:       cfg_low[2]   = data[cbf_pkg::LOW_W-1:0];
			cbf_pkg::REG_F2_WIDTH:     cfg_width[2] = data[cbf_pkg::WIDTH_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic write_all(input logic [cbf_pkg::CFG_DATA_W-1:0] off,
			input logic [cbf_pkg::CFG_DATA_W-1:0] fc,
			input logic [cbf_pkg::CFG_DATA_W-1:0] l0, input logic [cbf_pkg::CFG_DATA_W-1:0] w0,
			input logic [cbf_pkg::CFG_DATA_W-1:0] l1, input logic [cbf_pkg::CFG_DATA_W-1:0] w1,
			input logic [cbf_pkg::CFG_DATA_W-1:0] l2, input logic [cbf_pkg::CFG_DATA_W-1:0] w2);
		write_reg(cbf_pkg::REG_BLOCK_OFFSET, off);
		write_reg(cbf_pkg::REG_FIELD_COUNT, fc);
		write_reg(cbf_pkg::REG_F0_LOW, l0);
		write_reg(cbf_pkg::REG_F0_WIDTH, w0);
		write_reg(cbf_pkg::REG_F1_LOW, l1);
		write_reg(cbf_pkg::REG_F1_WIDTH, w1);
		write_reg(cbf_pkg::REG_F2_LOW, l2);
		write_reg(cbf_pkg::REG_F2_WIDTH, w2);
	endtask

	task automatic set_pacing(input int sp, input int rp, input int hold);
		@(posedge clk);
		send_pace    = sp;
		recv_pace    = rp;
		hold_request = hold;
	endtask

	task automatic queue_lookup(input logic [cbf_pkg::OP_W-1:0] op,
			input logic [cbf_pkg::ADDR_W-1:0] addr);
		lookup_t req;
		req.op      = op;
		req.address = addr;
		pending_lookups.push_back(req);
	endtask

	task automatic run_random(input int n, input int inc_pct, input int dec_pct);
		logic [cbf_pkg::ADDR_W-1:0] hot_addrs [8];
		logic [cbf_pkg::ADDR_W-1:0] addr;
		logic [cbf_pkg::OP_W-1:0]   op;
		int                         r, k;
		for (k = 0; k < 8; k++)
			hot_addrs[k] = {$urandom, $urandom};
		for (k = 0; k < n; k++) begin
			r = $urandom_range(0, 99);
			if (r < inc_pct)
				op = cbf_pkg::OP_INC;
			else if (r < inc_pct + dec_pct)
				op = cbf_pkg::OP_DEC;
			else if (r < 95)
				op = cbf_pkg::OP_QUERY;
			else
				op = OP_SPARE;
			r = $urandom_range(0, 99);
			// reuse a few addresses so counters climb and neighbors collide
			if (r < 50)
				addr = hot_addrs[$urandom_range(0, 7)];
			else if (r < 55)
				addr = hot_addrs[$urandom_range(0, 7)] ^ (64'd1 << $urandom_range(0, 63));
			else if (r < 57)
				addr = '1;
			else if (r < 59)
				addr = '0;
			else
				addr = {$urandom, $urandom};
			queue_lookup(op, addr);
		end
	endtask

	task automatic wait_drained();
		while (pending_lookups.size() != 0 || s_tvalid || awaited_tallies.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	// input side: take accepted items, then offer the next one at the falling edge
	always @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			apply_filter_op(cur_lookup);
			item_done = 1'b1;
		end
	end

	always @(negedge clk) begin : send_side
		logic [cbf_pkg::S_TDATA_W-1:0] word;
		if (arst_n && (item_done || !s_tvalid)) begin
			item_done = 1'b0;
			if (send_wait > 0) begin
				send_wait--;
				s_tvalid <= 1'b0;
			end else if (pending_lookups.size() != 0) begin
				cur_lookup = pending_lookups.pop_front();
				word = '0;
				word[cbf_pkg::OP_W-1:0]               = cur_lookup.op;
				word[cbf_pkg::OP_W +: cbf_pkg::ADDR_W] = cur_lookup.address;
				s_tdata  <= word;
				s_tvalid <= 1'b1;
				send_wait = draw_wait(send_pace);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// output side: compare each result against the oldest prediction
	always @(posedge clk) begin : result_check
		tally_t                            want;
		logic [cbf_pkg::COUNT_W-1:0]       got_count;
		logic [cbf_pkg::ENTRY_INDEX_W-1:0] got_index;
		if (m_tvalid && m_tready) begin
			result_seen = 1'b1;
			got_count = m_tdata[cbf_pkg::COUNT_W-1:0];
			got_index = m_tdata[cbf_pkg::COUNT_W +: cbf_pkg::ENTRY_INDEX_W];
			if (awaited_tallies.size() == 0) begin
				$error("unexpected result: count %0d entry_index %0d", got_count, got_index);
				fail_count++;
			end else begin
				want = awaited_tallies.pop_front();
				if (got_count !== want.count) begin
					$error("count mismatch: expected %0d, actual %0d", want.count, got_count);
					fail_count++;
				end
				if (got_index !== want.entry_index) begin
					$error("entry_index mismatch: expected %0d, actual %0d",
						want.entry_index, got_index);
					fail_count++;
				end
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_request > 0) begin
				hold_left    = hold_request;
				hold_request = 0;
			end
			if (result_seen) begin
				result_seen = 1'b0;
				stall_left  = draw_wait(recv_pace);
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin : stimulus
		int i, ph;
		for (i = 0; i < TABLE_DEPTH; i++)
			filter_counts[i] = '0;
		cfg_offset   = cbf_pkg::RST_BLOCK_OFFSET;
		cfg_fcount   = cbf_pkg::RST_FIELD_COUNT;
		cfg_low[0]   = cbf_pkg::RST_F0_LOW;
		cfg_low[1]   = cbf_pkg::RST_F1_LOW;
		cfg_low[2]   = cbf_pkg::RST_F2_LOW;
		for (i = 0; i < cbf_pkg::NUM_FIELDS; i++)
			cfg_width[i] = cbf_pkg::RST_FIELD_WIDTH;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset settings: index is address bits 17:6
		queue_lookup(cbf_pkg::OP_QUERY, 64'h0);
		queue_lookup(cbf_pkg::OP_INC,   64'h0);
		queue_lookup(cbf_pkg::OP_INC,   64'h0);
		queue_lookup(cbf_pkg::OP_INC,   64'h40);
		queue_lookup(cbf_pkg::OP_DEC,   64'h0);
		queue_lookup(cbf_pkg::OP_DEC,   64'h0);
		queue_lookup(cbf_pkg::OP_DEC,   64'h0);
		queue_lookup(cbf_pkg::OP_QUERY, 64'h0);
		queue_lookup(cbf_pkg::OP_INC,   '1);
		queue_lookup(OP_SPARE,          '1);
		queue_lookup(cbf_pkg::OP_DEC,   '1);
		queue_lookup(cbf_pkg::OP_DEC,   '1);
		queue_lookup(cbf_pkg::OP_INC,   64'h3f);
		queue_lookup(cbf_pkg::OP_INC,   64'hffff_ffff_fffc_003f);
		queue_lookup(cbf_pkg::OP_QUERY, 64'h2_0000);
		queue_lookup(cbf_pkg::OP_INC,   64'h8000_0000_0000_0000);
		queue_lookup(OP_SPARE,          64'h8000_0000_0000_0000);
		queue_lookup(cbf_pkg::OP_DEC,   64'h5555_aaaa_5555_aaaa);
		wait_drained();

		for (ph = 0; ph < 8; ph++) begin
			case (ph)
				0: begin
					write_all(8'd0, 8'd3, 8'd0, 8'd12, 8'd12, 8'd12, 8'd24, 8'd12);
					write_reg(REG_NONE, 8'hff);
					write_reg(8'($urandom_range(8, 254)), 8'($urandom));
					set_pacing(PACE_FULL, PACE_FULL, 0);
					run_random(220, 40, 25);
				end
				1: begin
					// everything lands on entry zero, pushing it into saturation
					write_all(8'd63, 8'd0, 8'd63, 8'd15, 8'd63, 8'd0, 8'd63, 8'd0);
					set_pacing(PACE_NONE, PACE_LIGHT, 300);
					run_random(320, 92, 3);
				end
				2: begin
					// fields straddling or above the top of the address
					write_all(8'd60, 8'd3, 8'd0, 8'd12, 8'd63, 8'd15, 8'd2, 8'd0);
					set_pacing(PACE_LIGHT, PACE_FULL, 0);
					run_random(220, 30, 45);
				end
				3: begin
					write_all(8'd0, 8'd2, 8'd63, 8'd1, 8'd0, 8'd1, 8'd5, 8'd3);
					set_pacing(PACE_FULL, PACE_NONE, 0);
					run_random(260, 50, 40);
				end
				default: begin
					for (i = 0; i < 8; i++)
						write_reg(cbf_pkg::CFG_IDX_W'(i), 8'($urandom));
					set_pacing(ph == 5 ? PACE_NONE : (ph == 4 ? PACE_LIGHT : PACE_FULL),
						ph == 6 ? PACE_LIGHT : (ph == 5 ? PACE_NONE : PACE_FULL), 0);
					run_random(230, 40, 35);
				end
			endcase
			wait_drained();
		end

		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

FILE: xor_field_counting_bloom_filter_top.f
hdl/cbf_pkg.sv
hdl/cbf_hash.sv
hdl/cbf_table.sv
hdl/xor_field_counting_bloom_filter_top.sv
verif/tb_top.sv
